### hdl/bafl_pkg.sv
`default_nettype none

package bafl_pkg;

  // Fixed field widths of the transfer items
  localparam int ADDR_W     = 16;
  localparam int PTR_W      = ADDR_W + 1;
  localparam int STORE_AW   = ADDR_W - 3;
  localparam int ACTION_W   = 3;
  localparam int STATUS_W   = 2;

  localparam int FREE_SLOTS_DEF   = 32;
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic [PTR_W-1:0] ALIGN_LOW  = PTR_W'(7);
  localparam logic [PTR_W-1:0] ARENA_SPAN = {1'b1, {ADDR_W{1'b0}}};

  // s_axis_tdata: request_bytes, block_offset, restore_mark, zero fill
  localparam int IN_TDATA_W  = ((2 * ADDR_W + PTR_W + 7) / 8) * 8;
  // m_axis_tdata: data_offset, status, used_now, zero fill
  localparam int OUT_TDATA_W = ((ADDR_W + STATUS_W + PTR_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_RESET   = 3'd2,
    ACT_MARK    = 3'd3,
    ACT_RELEASE = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_PICK,
    S_FREE_WAIT
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DIRECT,
    OP_PICK,
    OP_PUSH
  } op_e;

  typedef struct packed {
    logic load;
    logic match_en;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic free_go;
    logic out_room;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/bafl_ram.sv
`default_nettype none

module bafl_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/bafl_ctrl.sv
`default_nettype none

module bafl_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bafl_pkg::dp_stat_t   stat_i,
  output bafl_pkg::ctrl_cmd_t       cmd_o
);

  import bafl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.match_en = 1'b0;
    cmd_o.op       = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_alloc) begin
          cmd_o.match_en = 1'b1;
          state_d        = S_PICK;
        end else if (stat_i.free_go) begin
          // size entry read is in flight
          state_d = S_FREE_WAIT;
        end else if (stat_i.out_room) begin
          cmd_o.op = OP_DIRECT;
          state_d  = S_IDLE;
        end
      end
      S_PICK: begin
        if (stat_i.out_room) begin
          cmd_o.op = OP_PICK;
          state_d  = S_IDLE;
        end
      end
      S_FREE_WAIT: begin
        if (stat_i.out_room) begin
          cmd_o.op = OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/bafl_dp.sv
`default_nettype none

module bafl_dp #(
  parameter int FREE_SLOTS   = bafl_pkg::FREE_SLOTS_DEF,
  parameter int HEADER_BYTES = bafl_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [bafl_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  wire logic [bafl_pkg::ACTION_W-1:0]       in_action_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic [bafl_pkg::PTR_W-1:0]          cfg_data_i,
  input  wire bafl_pkg::ctrl_cmd_t                 cmd_i,
  output bafl_pkg::dp_stat_t                       stat_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [bafl_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  import bafl_pkg::*;

  localparam int IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CNT_W = $clog2(FREE_SLOTS + 1);
  localparam int SUM_W = PTR_W + 2;
  localparam logic [PTR_W-1:0] HDR   = PTR_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(FREE_SLOTS);

  // Latched item
  action_e           action_q;
  logic [PTR_W-1:0]  size_q;
  logic [ADDR_W-1:0] off_q;
  logic [PTR_W-1:0]  mark_q;

  logic [PTR_W-1:0]  cap_q;
  logic [PTR_W-1:0]  bump_q, bump_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [ADDR_W-1:0] offs_q  [FREE_SLOTS];
  logic [PTR_W-1:0]  sizes_q [FREE_SLOTS];
  logic [FREE_SLOTS-1:0] match_q;

  logic              out_valid_q;
  logic [ADDR_W-1:0] res_off_q, res_off_d;
  status_e           res_st_q, res_st_d;
  logic [PTR_W-1:0]  res_used_q;

  logic [ADDR_W-1:0] req_in;
  logic [PTR_W-1:0]  size_in;

  logic              hit;
  logic [IDX_W-1:0]  pick_idx;
  logic [PTR_W:0]    need;
  logic [SUM_W-1:0]  bump_end;
  logic [PTR_W:0]    data_off;
  logic              bump_ok;
  logic              in_range;
  logic              list_full;
  logic [ADDR_W-1:0] hdr_off;
  logic [PTR_W-1:0]  ram_rdata;
  logic              ram_we;
  logic              do_shift;
  logic              do_push;

  assign req_in  = in_data_i[ADDR_W-1:0];
  assign size_in = ({1'b0, req_in} + ALIGN_LOW) & ~ALIGN_LOW;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_e'(in_action_i);
      size_q   <= size_in;
      off_q    <= in_data_i[2*ADDR_W-1:ADDR_W];
      mark_q   <= in_data_i[2*ADDR_W+PTR_W-1:2*ADDR_W];
    end
  end

  // Capacity register, clamped to the address span
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ARENA_SPAN;
    end else if (cfg_valid_i) begin
      cap_q <= (cfg_data_i > ARENA_SPAN) ? ARENA_SPAN : cfg_data_i;
    end
  end

  // First-fit search: compare every live entry, then take the topmost hit
  always_ff @(posedge clk_i) begin
    if (cmd_i.match_en) begin
      for (int j = 0; j < FREE_SLOTS; j++) begin
        match_q[j] <= (CNT_W'(j) < cnt_q) && (sizes_q[j] >= size_q);
      end
    end
  end

  always_comb begin
    hit      = 1'b0;
    pick_idx = '0;
    for (int j = 0; j < FREE_SLOTS; j++) begin
      if (match_q[j]) begin
        hit      = 1'b1;
        pick_idx = IDX_W'(j);
      end
    end
  end

  // Bump path
  assign need     = {1'b0, size_q} + {1'b0, HDR};
  assign bump_end = {2'b00, bump_q} + {1'b0, need};
  assign data_off = {1'b0, bump_q} + {1'b0, HDR};
  assign bump_ok  = (bump_end <= {2'b00, cap_q}) && (data_off[PTR_W:ADDR_W] == '0);

  // Free path
  assign in_range  = ({1'b0, off_q} >= HDR) && ({1'b0, off_q} <= bump_q);
  assign list_full = (cnt_q >= SLOTS);
  assign hdr_off   = off_q - HDR[ADDR_W-1:0];

  assign ram_we   = (cmd_i.op == OP_PICK) && !hit && bump_ok;
  assign do_shift = (cmd_i.op == OP_PICK) && hit;
  assign do_push  = (cmd_i.op == OP_PUSH);

  bafl_ram #(
    .WIDTH (PTR_W),
    .DEPTH (1 << STORE_AW)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bump_q[ADDR_W-1:3]),
    .wdata_i (size_q),
    .raddr_i (hdr_off[ADDR_W-1:3]),
    .rdata_o (ram_rdata)
  );

  // Free list entries: push at the top, or close the gap left by a pick
  for (genvar j = 0; j < FREE_SLOTS; j++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (do_push && (cnt_q[IDX_W-1:0] == IDX_W'(j))) begin
        offs_q[j]  <= off_q;
        sizes_q[j] <= ram_rdata;
      end else if (do_shift && (IDX_W'(j) >= pick_idx)) begin
        if (j < FREE_SLOTS - 1) begin
          offs_q[j]  <= offs_q[(j + 1) % FREE_SLOTS];
          sizes_q[j] <= sizes_q[(j + 1) % FREE_SLOTS];
        end
      end
    end
  end

  always_comb begin
    bump_d    = bump_q;
    cnt_d     = cnt_q;
    res_off_d = '0;
    res_st_d  = STAT_OK;
    unique case (cmd_i.op)
      OP_DIRECT: begin
        unique case (action_q)
          ACT_FREE:    res_st_d = in_range ? STAT_FULL : STAT_RANGE;
          ACT_RESET: begin
            bump_d = '0;
            cnt_d  = '0;
          end
          ACT_RELEASE: bump_d = mark_q;
          default: ;
        endcase
      end
      OP_PICK: begin
        if (hit) begin
          res_off_d = offs_q[pick_idx];
          cnt_d     = cnt_q - CNT_W'(1);
        end else if (bump_ok) begin
          res_off_d = data_off[ADDR_W-1:0];
          bump_d    = bump_end[PTR_W-1:0];
        end else begin
          res_st_d = STAT_OOM;
        end
      end
      OP_PUSH: cnt_d = cnt_q + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bump_q <= bump_d;
      cnt_q  <= cnt_d;
      if (cmd_i.op != OP_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) begin
      res_off_q  <= res_off_d;
      res_st_q   <= res_st_d;
      res_used_q <= bump_d;
    end
  end

  assign stat_o.is_alloc = (action_q == ACT_ALLOC);
  assign stat_o.free_go  = (action_q == ACT_FREE) && in_range && !list_full;
  assign stat_o.out_room = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_TDATA_W - ADDR_W - STATUS_W - PTR_W){1'b0}},
                        res_used_q, res_st_q, res_off_q};

endmodule

`default_nettype wire

### hdl/bump_allocator_with_free_list_core.sv
`default_nettype none

// Arena allocator handing out byte offsets, with a last-freed-first free list
// searched first-fit before the bump pointer advances. One item is in work at
// a time. An alloc, or a free that passes the range and list-full checks,
// runs from its input transfer to its result through latch, free-list compare
// or size-store read, and commit. Other actions, and a rejected free, run
// through latch and commit. The block takes the next item as soon as the
// previous one has committed into the output register, and a commit waits
// only while that register still holds a result that has not been taken.
// The free-list compare covers all entries at once; the per-block size store
// is a single RAM with a registered read, which sets the extra read step on a
// free. The size store needs no clearing after reset. Capacity writes are
// taken at any time and clamp to the arena's address span.
module bump_allocator_with_free_list_core #(
  parameter int FREE_SLOTS   = bafl_pkg::FREE_SLOTS_DEF,
  parameter int HEADER_BYTES = bafl_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request_bytes [15:0], block_offset [31:16], restore_mark [48:32]
  input  wire logic [bafl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action
  input  wire logic [bafl_pkg::ACTION_W-1:0]     s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // data_offset [15:0], status [17:16], used_now [34:18]
  output logic      [bafl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bafl_pkg::PTR_W-1:0]        cfg_data_i
);

  import bafl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  bafl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bafl_dp #(
    .FREE_SLOTS   (FREE_SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_action_i (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### hdl/bafl_checker.sv
`default_nettype none

module bafl_checker #(
  parameter int HEADER_BYTES = bafl_pkg::HEADER_BYTES_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [bafl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready
);

  import bafl_pkg::*;

  logic [ADDR_W-1:0]   res_off;
  logic [STATUS_W-1:0] res_st;

  assign res_off = m_axis_tdata[ADDR_W-1:0];
  assign res_st  = m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W];

  // One item at a time: the input side closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous item in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_error_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_st != STAT_OK)) |-> (res_off == '0))
    else $error("failed request returned an offset");

  // Granted data always sits behind a header
  a_grant_past_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_off != '0)) |-> ({1'b0, res_off} >= PTR_W'(HEADER_BYTES)))
    else $error("granted offset inside header area");

endmodule

bind bump_allocator_with_free_list_core bafl_checker #(
  .HEADER_BYTES (HEADER_BYTES)
) u_bafl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

### test/bump_allocator_with_free_list_core_tb.sv
`timescale 1ns / 100ps

module bump_allocator_with_free_list_core_tb;
  import bafl_pkg::*;

  localparam int HDR         = HEADER_BYTES_DEF;
  localparam int SLOTS       = FREE_SLOTS_DEF;
  localparam int PHASE_OPS   = 318;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RECENT_MAX  = 64;
  localparam logic [ACTION_W-1:0] ACT_CODE_MAX = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   request_bytes;
    logic [ADDR_W-1:0]   block_offset;
    logic [PTR_W-1:0]    restore_mark;
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] data_offset;
    status_e           status;
    logic [PTR_W-1:0]  used_now;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]    s_axis_tuser = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [PTR_W-1:0]       cfg_data_i = '0;

  // arena mirror
  logic [PTR_W-1:0]  arena_limit = ARENA_SPAN;
  logic [PTR_W-1:0]  used_ptr = '0;
  logic [ADDR_W-1:0] list_off [SLOTS];
  logic [PTR_W-1:0]  list_size [SLOTS];
  int                list_len = 0;
  logic [PTR_W-1:0]  hdr_size [1 << STORE_AW];
  bit                hdr_known [1 << STORE_AW];
  int                known_hdr_q [$];
  int                recent_hdr_q [$];

  op_t    request_q [$];
  grant_t grant_q [$];

  logic [PTR_W-1:0] last_used_now = '0;
  int fail_cnt = 0;
  int ops_queued = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int s_gap_max = 19;
  int stall_left = 0;
  int m_stall_max = 19;
  int n_bumped = 0, n_reused = 0, n_oom = 0, n_range = 0, n_full = 0, n_caps = 0;

  bump_allocator_with_free_list_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Advance the arena mirror by one request and return the grant it yields.
  function automatic grant_t arena_step(input logic [ACTION_W-1:0] act,
                                        input logic [ADDR_W-1:0] req,
                                        input logic [ADDR_W-1:0] off,
                                        input logic [PTR_W-1:0] mark);
    grant_t g;
    int size_b;
    int pick;
    int idx;
    g = '{data_offset: '0, status: STAT_OK, used_now: '0};
    case (act)
      ACT_ALLOC: begin
        size_b = int'((PTR_W'(req) + ALIGN_LOW) & ~ALIGN_LOW);
        pick = -1;
        for (int k = list_len - 1; k >= 0; k--) begin
          if (pick < 0 && int'(list_size[k]) >= size_b) pick = k;
        end
        if (pick >= 0) begin
          g.data_offset = list_off[pick];
          for (int j = pick; j < list_len - 1; j++) begin
            list_off[j] = list_off[j + 1];
            list_size[j] = list_size[j + 1];
          end
          list_len--;
          n_reused++;
        end else if (int'(used_ptr) + size_b + HDR <= int'(arena_limit) &&
                     int'(used_ptr) + HDR < int'(ARENA_SPAN)) begin
          idx = int'(used_ptr) >> 3;
          hdr_size[idx] = PTR_W'(size_b);
          if (!hdr_known[idx]) begin
            hdr_known[idx] = 1'b1;
            known_hdr_q.push_back(idx);
          end
          recent_hdr_q.push_back(idx);
          if (recent_hdr_q.size() > RECENT_MAX) void'(recent_hdr_q.pop_front());
          g.data_offset = ADDR_W'(int'(used_ptr) + HDR);
          used_ptr = PTR_W'(int'(used_ptr) + size_b + HDR);
          n_bumped++;
        end else begin
          g.status = STAT_OOM;
          n_oom++;
        end
      end
      ACT_FREE: begin
        if (int'(off) < HDR || int'(off) > int'(used_ptr)) begin
          g.status = STAT_RANGE;
          n_range++;
        end else if (list_len >= SLOTS) begin
          g.status = STAT_FULL;
          n_full++;
        end else begin
          list_off[list_len] = off;
          list_size[list_len] = hdr_size[(int'(off) - HDR) >> 3];
          list_len++;
        end
      end
      ACT_RESET: begin
        used_ptr = '0;
        list_len = 0;
      end
      ACT_RELEASE: used_ptr = mark;
      default: ;
    endcase
    g.used_now = used_ptr;
    return g;
  endfunction

  // Target a block whose size entry is known to be written, or fall below the header.
  function automatic logic [ADDR_W-1:0] free_target();
    int idx;
    int mis;
    if (recent_hdr_q.size() == 0 || $urandom_range(0, 9) == 0)
      return ADDR_W'($urandom_range(0, HDR - 1));
    if ($urandom_range(0, 3) == 0) idx = known_hdr_q[$urandom_range(0, known_hdr_q.size() - 1)];
    else idx = recent_hdr_q[$urandom_range(0, recent_hdr_q.size() - 1)];
    mis = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
    return ADDR_W'(idx * 8 + HDR + mis);
  endfunction

  // Mostly small requests, now and then up to the full field.
  function automatic logic [ADDR_W-1:0] rand_req();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return ADDR_W'($urandom_range(0, 64));
    if (r < 14) return ADDR_W'($urandom_range(0, 1024));
    if (r < 15) return ADDR_W'($urandom_range(0, 8191));
    return ADDR_W'($urandom_range(0, 65535));
  endfunction

  task automatic push_op(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] req,
                         input logic [ADDR_W-1:0] off, input logic [PTR_W-1:0] mark);
    op_t op;
    while (request_q.size() >= 2) @(negedge clk_i);
    op.action = act;
    op.request_bytes = req;
    op.block_offset = off;
    op.restore_mark = mark;
    request_q.push_back(op);
    ops_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0);
  endtask

  // Source side: one item per transfer, random gap after each.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() != 0) begin
        op = request_q.pop_front();
        s_axis_tuser <= op.action;
        s_axis_tdata <= IN_TDATA_W'({op.restore_mark, op.block_offset, op.request_bytes});
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 63) == 0) s_gap_max <= (s_gap_max == 0) ? 19 : 0;
        gap_left <= $urandom_range(0, s_gap_max);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: stall a random number of cycles after each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin : sink
    int nap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 63) == 0) m_stall_max <= (m_stall_max == 0) ? 19 : 0;
      nap = $urandom_range(0, m_stall_max);
      m_axis_tready <= (nap == 0);
      stall_left <= (nap == 0) ? 0 : nap - 1;
    end else if (!m_axis_tready) begin
      if (stall_left == 0) m_axis_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin : monitor
    grant_t got;
    grant_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      grant_q.push_back(arena_step(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                   s_axis_tdata[48:32]));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data_offset = m_axis_tdata[15:0];
      got.status = status_e'(m_axis_tdata[17:16]);
      got.used_now = m_axis_tdata[34:18];
      last_used_now = got.used_now;
      if (grant_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_cnt++;
      end else begin
        want = grant_q.pop_front();
        if (got.data_offset !== want.data_offset) begin
          $error("data_offset: expected %0d, actual %0d", want.data_offset, got.data_offset);
          fail_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.used_now !== want.used_now) begin
          $error("used_now: expected %0d, actual %0d", want.used_now, got.used_now);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bump_allocator_with_free_list_core_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PTR_W-1:0] cap;
    logic [PTR_W-1:0] scope_mark;
    logic [ACTION_W-1:0] act;
    int phase_start;
    int pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: cap = ARENA_SPAN;
        1: cap = '0;
        2: cap = '1;            // above the span, clamps
        3: cap = PTR_W'(512);
        4: cap = PTR_W'($urandom_range(1, 65535));
        default: cap = ARENA_SPAN;
      endcase
      @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_data_i <= cap;
      do @(posedge clk_i);
      while (!cfg_ready_o);
      arena_limit = (cap > ARENA_SPAN) ? ARENA_SPAN : cap;
      n_caps++;
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);

      if (p == 0) begin
        push_op(ACT_FREE, '0, '0, '0);                 // below the header
        push_op(ACT_FREE, '0, ADDR_W'(HDR), '0);       // past an empty arena
        push_op(ACT_ALLOC, '0, '0, '0);
        push_op(ACT_ALLOC, 16'd1, '0, '0);
        push_op(ACT_ALLOC, 16'd7, '0, '0);
        push_op(ACT_FREE, '0, ADDR_W'(HDR), '0);
        push_op(ACT_FREE, '0, 16'd32, '0);
        push_op(ACT_FREE, '0, 16'd35, '0);             // misaligned, shares a size entry
        push_op(ACT_FREE, '0, 16'd32, '0);             // same block again
        push_op(ACT_ALLOC, 16'd8, '0, '0);
        push_op(ACT_ALLOC, 16'd9, '0, '0);
        push_op(ACT_FREE, '0, '1, '0);
        push_op(ACT_FREE, '0, ADDR_W'(HDR - 1), '0);
        push_op(ACT_MARK, '0, '0, '0);
        push_op(ACT_RELEASE, '0, '0, ARENA_SPAN);
        push_op(ACT_ALLOC, '1, '0, '0);
        push_op(ACT_RESET, '0, '0, '0);
        push_op(ACT_RELEASE, '0, '0, 17'd65519);
        push_op(ACT_ALLOC, '0, '0, '0);                // grants the top data offset
        push_op(ACT_RELEASE, '0, '0, 17'd65520);
        push_op(ACT_ALLOC, '0, '0, '0);                // data offset leaves the address range
        push_op(ACT_RELEASE, '0, '0, 17'd65535);
        push_op(ACT_FREE, '1, '1, '1);
        push_op(3'(ACT_RELEASE + 1), '1, '1, '1);
        push_op(ACT_CODE_MAX, '0, '0, '0);
      end

      phase_start = ops_queued;
      while (ops_queued - phase_start < PHASE_OPS) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          repeat ($urandom_range(1, 8))
            push_op(ACT_ALLOC, rand_req(), ADDR_W'($urandom), PTR_W'($urandom));
        end else if (pick < 10) begin
          repeat ($urandom_range(1, 40))
            push_op(ACT_FREE, ADDR_W'($urandom), free_target(), PTR_W'($urandom));
        end else if (pick < 13) begin
          repeat ($urandom_range(1, 6))
            push_op(ACT_ALLOC, ADDR_W'($urandom_range(0, 64)), '0, '0);
        end else if (pick < 16) begin
          // scope: take a mark, allocate and free inside it, then drop back to it
          push_op(ACT_MARK, ADDR_W'($urandom), ADDR_W'($urandom), PTR_W'($urandom));
          wait_drained();
          scope_mark = last_used_now;
          repeat ($urandom_range(1, 6)) begin
            push_op(ACT_ALLOC, rand_req(), '0, '0);
            if ($urandom_range(0, 2) == 0) push_op(ACT_FREE, '0, free_target(), '0);
          end
          push_op(ACT_RELEASE, ADDR_W'($urandom), ADDR_W'($urandom), scope_mark);
        end else if (pick < 19) begin
          act = ACTION_W'($urandom_range(0, ACT_CODE_MAX));
          if (act == ACT_RESET && $urandom_range(0, 3) != 0) act = ACT_MARK;
          push_op(act, ADDR_W'($urandom),
                  (act == ACT_FREE) ? free_target() : ADDR_W'($urandom),
                  PTR_W'($urandom_range(0, 32'h10000)));
        end else begin
          push_op(ACT_RESET, ADDR_W'($urandom), ADDR_W'($urandom), PTR_W'($urandom));
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d requests over %0d capacity settings: %0d bump grants, %0d reused blocks,",
             ops_queued, n_caps, n_bumped, n_reused);
    $display("%0d out of memory, %0d frees out of range, %0d frees dropped on a full list.",
             n_oom, n_range, n_full);
    if (fail_cnt == 0) begin
      $display("bump_allocator_with_free_list_core_tb: PASS");
    end else begin
      $display("bump_allocator_with_free_list_core_tb: FAIL");
    end
    $finish;
  end

endmodule
